### sv/cqf_pkg.sv
// Shared types, constants and codes of the circular queue FIFO.
package cqf_pkg;

    // Storage size and word width.
    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CAP_W     = $clog2(DEPTH + 1);

    // Reset value of the capacity register.
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    // Command codes carried by an input item.
    typedef enum logic [1:0] {
        CMD_ENQ        = 2'd0,
        CMD_DEQ        = 2'd1,
        CMD_PEEK_FRONT = 2'd2,
        CMD_PEEK_REAR  = 2'd3
    } t_cmd;

    // Status codes returned with each result item.
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    // Control states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

    // Request from the controller to the slot memory.
    typedef struct packed {
        logic                 we;
        logic [IDX_W-1:0]     waddr;
        logic [WORD_BITS-1:0] wdata;
        logic                 re;
        logic [IDX_W-1:0]     raddr;
    } t_mem_req;

endpackage

### sv/cqf_ram.sv
// Slot memory of the queue: one write port and one registered read port.
module cqf_ram (
    input  logic                          i_clk,
    input  cqf_pkg::t_mem_req             i_req,
    output logic [cqf_pkg::WORD_BITS-1:0] o_rdata
);

    logic [cqf_pkg::WORD_BITS-1:0] r_mem [cqf_pkg::DEPTH];
    logic [cqf_pkg::WORD_BITS-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/cqf_ctrl.sv
// Queue controller: pointers, capacity register, command decode and result register.
module cqf_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cqf_pkg::CAP_W-1:0]            i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_cmd,
    input  logic signed [cqf_pkg::WORD_BITS-1:0] i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [cqf_pkg::WORD_BITS-1:0] o_data,
    output logic [1:0]                           o_status,
    output cqf_pkg::t_mem_req                    o_mem_req,
    input  logic [cqf_pkg::WORD_BITS-1:0]        i_mem_rdata
);

    cqf_pkg::t_state              r_state, n_state;
    logic [cqf_pkg::CAP_W-1:0]    r_cap;
    logic [cqf_pkg::IDX_W-1:0]    r_head, n_head;
    logic [cqf_pkg::IDX_W-1:0]    r_tail, n_tail;
    logic                         r_empty, n_empty;
    logic                         r_use_mem, n_use_mem;
    logic [cqf_pkg::WORD_BITS-1:0] r_data, n_data;
    cqf_pkg::t_status             r_status, n_status;

    logic                         accept;
    logic [cqf_pkg::CAP_W-1:0]    eff_cap;
    logic [cqf_pkg::CAP_W-1:0]    head_inc, tail_inc;
    logic [cqf_pkg::IDX_W-1:0]    head_adv, tail_adv;
    cqf_pkg::t_cmd                cmd;

    assign cmd    = cqf_pkg::t_cmd'(i_cmd);
    assign accept = i_in_valid && !o_in_stall;

    // Capacity in force: zero acts as one, anything above the depth as the depth.
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = cqf_pkg::CAP_W'(1);
        end else if (r_cap > cqf_pkg::CAP_W'(cqf_pkg::DEPTH)) begin
            eff_cap = cqf_pkg::CAP_W'(cqf_pkg::DEPTH);
        end else begin
            eff_cap = r_cap;
        end
    end

    // Pointer steps wrap to zero at the capacity.
    always_comb begin
        head_inc = {1'b0, r_head} + cqf_pkg::CAP_W'(1);
        tail_inc = {1'b0, r_tail} + cqf_pkg::CAP_W'(1);
        head_adv = (head_inc >= eff_cap) ? '0 : head_inc[cqf_pkg::IDX_W-1:0];
        tail_adv = (tail_inc >= eff_cap) ? '0 : tail_inc[cqf_pkg::IDX_W-1:0];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cqf_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = cqf_pkg::ST_RESP;
                end
            end
            cqf_pkg::ST_RESP: begin
                if (!i_out_stall && !accept) begin
                    n_state = cqf_pkg::ST_IDLE;
                end
            end
            default: n_state = cqf_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs: a new item enters as soon as the pending result leaves.
    always_comb begin
        o_in_stall  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            cqf_pkg::ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_out_valid = 1'b0;
            end
            cqf_pkg::ST_RESP: begin
                o_in_stall  = i_out_stall;
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall  = 1'b1;
                o_out_valid = 1'b0;
            end
        endcase
    end

    // Command decode: pointer update, memory access and result fields.
    always_comb begin
        n_head            = r_head;
        n_tail            = r_tail;
        n_empty           = r_empty;
        n_use_mem         = r_use_mem;
        n_data            = r_data;
        n_status          = r_status;
        o_mem_req.we      = 1'b0;
        o_mem_req.waddr   = '0;
        o_mem_req.wdata   = i_value;
        o_mem_req.re      = 1'b0;
        o_mem_req.raddr   = r_head;
        if (accept) begin
            n_use_mem = 1'b0;
            n_data    = '0;
            n_status  = cqf_pkg::STS_OK;
            if (cmd == cqf_pkg::CMD_ENQ) begin
                if (r_empty) begin
                    n_head          = '0;
                    n_tail          = '0;
                    n_empty         = 1'b0;
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = '0;
                end else if (tail_adv == r_head) begin
                    n_status = cqf_pkg::STS_FULL;
                end else begin
                    n_tail          = tail_adv;
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = tail_adv;
                end
            end else if (r_empty) begin
                n_data   = '1;
                n_status = cqf_pkg::STS_EMPTY;
            end else begin
                n_use_mem    = 1'b1;
                o_mem_req.re = 1'b1;
                case (cmd)
                    cqf_pkg::CMD_DEQ: begin
                        o_mem_req.raddr = r_head;
                        if (r_head == r_tail) begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_empty = 1'b1;
                        end else begin
                            n_head = head_adv;
                        end
                    end
                    cqf_pkg::CMD_PEEK_REAR: o_mem_req.raddr = r_tail;
                    default:                o_mem_req.raddr = r_head;
                endcase
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cqf_pkg::ST_IDLE;
            r_cap   <= cqf_pkg::CAP_RESET;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_use_mem <= n_use_mem;
        r_data    <= n_data;
        r_status  <= n_status;
    end

    // Read results come straight from the memory's output register.
    assign o_data   = r_use_mem ? i_mem_rdata : r_data;
    assign o_status = r_status;

endmodule

### sv/circular_queue_fifo_top.sv
// Top level of the circular queue FIFO: controller and slot memory.
//
// A circular FIFO of signed 32-bit words held in a 16-entry synchronous memory.
// Each command item (enqueue, dequeue, peek front, peek rear) yields exactly one
// result item with a data word and a status (ok, full, empty). An item's
// result appears in the cycle after it is accepted, for reads from the memory's
// registered read port. A new item is accepted in the same cycle that the
// pending result is taken, so with no stall on the output an item
// enters every cycle. The capacity register (1 to 16; zero acts as one and
// larger values as 16) may be written only while no item is in flight.
module circular_queue_fifo_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cqf_pkg::CAP_W-1:0]            i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_cmd,
    input  logic signed [cqf_pkg::WORD_BITS-1:0] i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [cqf_pkg::WORD_BITS-1:0] o_data,
    output logic [1:0]                           o_status
);

    cqf_pkg::t_mem_req              mem_req;
    logic [cqf_pkg::WORD_BITS-1:0]  mem_rdata;

    // Pointer and command logic.
    cqf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    // Slot storage.
    cqf_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

### tb/sv/circular_queue_fifo_top_tb.sv
// Self-checking testbench for the circular queue FIFO: directed table, random phases, scoreboard.
module circular_queue_fifo_top_tb;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 180;
    localparam int NUM_PHASES   = 10;
    localparam int HOLD_PHASE   = 4;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 4;

    // Per-phase capacity setting, sender idle rate and receiver stall rate (percent).
    localparam int PHASE_CAP   [NUM_PHASES] = '{16, 1, 0, 31, 4, 7, 2, 16, 11, 17};
    localparam int PHASE_IDLE  [NUM_PHASES] = '{0, 54, 0, 33, 0, 54, 0, 33, 0, 54};
    localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 54, 33, 0, 0, 54, 33, 0, 0};

    typedef struct {
        logic signed [cqf_pkg::WORD_BITS-1:0] data;
        cqf_pkg::t_status                     status;
    } t_queue_result;

    typedef struct {
        cqf_pkg::t_cmd                        cmd;
        logic signed [cqf_pkg::WORD_BITS-1:0] value;
        bit                                   typed;
        logic signed [cqf_pkg::WORD_BITS-1:0] data;
        cqf_pkg::t_status                     status;
    } t_stim_row;

    // Block ports.
    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_cfg_we    = 1'b0;
    logic [cqf_pkg::CAP_W-1:0]            i_cfg_wdata = '0;
    logic                                 i_in_valid  = 1'b0;
    logic                                 o_in_stall;
    logic [1:0]                           i_cmd       = cqf_pkg::CMD_ENQ;
    logic signed [cqf_pkg::WORD_BITS-1:0] i_value     = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b0;
    logic signed [cqf_pkg::WORD_BITS-1:0] o_data;
    logic [1:0]                           o_status;

    // Typed expectation that travels with a directed item.
    logic                                 row_typed  = 1'b0;
    logic signed [cqf_pkg::WORD_BITS-1:0] row_data   = '0;
    cqf_pkg::t_status                     row_status = cqf_pkg::STS_OK;

    // Mirror of the queue state.
    logic signed [cqf_pkg::WORD_BITS-1:0] ring_slots [cqf_pkg::DEPTH];
    int unsigned                          ring_head  = 0;
    int unsigned                          ring_tail  = 0;
    bit                                   ring_empty = 1'b1;
    logic [cqf_pkg::CAP_W-1:0]            ring_cap   = cqf_pkg::CAP_RESET;

    t_queue_result expected_results [$];
    t_stim_row     directed_rows [$];
    int            mismatches    = 0;
    int            results_seen  = 0;
    int            send_idle_pct = 0;
    int            stall_pct     = 0;
    bit            hold_go       = 1'b0;
    logic          hold_on       = 1'b0;
    int            cycle_count   = 0;

    circular_queue_fifo_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data      (o_data),
        .o_status    (o_status)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Capacity in effect: zero behaves as one, anything above the storage as full storage.
    function automatic int unsigned active_capacity();
        if (ring_cap == 0) return 1;
        if (ring_cap > cqf_pkg::DEPTH) return cqf_pkg::DEPTH;
        return ring_cap;
    endfunction

    function automatic int unsigned ring_next(int unsigned idx);
        return (idx + 1 >= active_capacity()) ? 0 : idx + 1;
    endfunction

    // Applies one command to the mirrored queue and returns the result it should produce.
    function automatic t_queue_result predict_queue_op(
        cqf_pkg::t_cmd cmd, logic signed [cqf_pkg::WORD_BITS-1:0] value);
        t_queue_result res;
        res.data   = '0;
        res.status = cqf_pkg::STS_OK;
        if (cmd == cqf_pkg::CMD_ENQ) begin
            if (ring_empty) begin
                ring_head     = 0;
                ring_tail     = 0;
                ring_slots[0] = value;
                ring_empty    = 1'b0;
            end else if (ring_next(ring_tail) == ring_head) begin
                res.status = cqf_pkg::STS_FULL;
            end else begin
                ring_tail             = ring_next(ring_tail);
                ring_slots[ring_tail] = value;
            end
        end else if (ring_empty) begin
            res.data   = -32'sd1;
            res.status = cqf_pkg::STS_EMPTY;
        end else if (cmd == cqf_pkg::CMD_DEQ) begin
            res.data = ring_slots[ring_head];
            if (ring_head == ring_tail) begin
                ring_head  = 0;
                ring_tail  = 0;
                ring_empty = 1'b1;
            end else begin
                ring_head = ring_next(ring_head);
            end
        end else if (cmd == cqf_pkg::CMD_PEEK_FRONT) begin
            res.data = ring_slots[ring_head];
        end else begin
            res.data = ring_slots[ring_tail];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d, want %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic add_row(cqf_pkg::t_cmd cmd, logic signed [cqf_pkg::WORD_BITS-1:0] value,
                           bit typed, logic signed [cqf_pkg::WORD_BITS-1:0] data,
                           cqf_pkg::t_status status);
        t_stim_row row;
        row.cmd    = cmd;
        row.value  = value;
        row.typed  = typed;
        row.data   = data;
        row.status = status;
        directed_rows.push_back(row);
    endtask

    // Offers one item after a random idle gap and returns at the edge that accepts it.
    task automatic offer_item(cqf_pkg::t_cmd cmd, logic signed [cqf_pkg::WORD_BITS-1:0] value,
                              bit typed, logic signed [cqf_pkg::WORD_BITS-1:0] data,
                              cqf_pkg::t_status status);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= value;
        row_typed  <= typed;
        row_data   <= data;
        row_status <= status;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Waits until every expected result has been taken and the block has settled.
    task automatic wait_drained();
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Scoreboard: checks taken results, then tracks configuration and accepted items.
    always @(posedge i_clk) begin
        t_queue_result want;
        t_queue_result predicted;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("with nothing pending, data", o_data, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_data !== want.data) report_mismatch("data", o_data, want.data);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            if (i_cfg_we) ring_cap = i_cfg_wdata;
            if (i_in_valid && !o_in_stall) begin
                predicted = predict_queue_op(cqf_pkg::t_cmd'(i_cmd), i_value);
                if (row_typed) begin
                    predicted.data   = row_data;
                    predicted.status = row_status;
                end
                expected_results.push_back(predicted);
            end
        end
    end

    // Receiver: random stalls, overridden by the long hold-off.
    always @(posedge i_clk) begin
        i_out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
    end

    // Long receiver hold-off so the pending result is held and the block stalls its input.
    initial begin
        wait (hold_go);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("circular_queue_fifo_top verification failed");
        $finish;
    end

    // Stimulus: directed table at reset capacity, then random phases.
    initial begin
        int unsigned                          mood_left;
        bit                                   enq_heavy;
        int unsigned                          pick;
        cqf_pkg::t_cmd                        pick_cmd;
        logic signed [cqf_pkg::WORD_BITS-1:0] pick_value;

        // Empty-queue reads, a single entry in and out, then fill to full and peek both ends.
        add_row(cqf_pkg::CMD_DEQ,        32'sh5A5A_A5A5, 1'b1, -32'sd1, cqf_pkg::STS_EMPTY);
        add_row(cqf_pkg::CMD_PEEK_FRONT, 32'sh7FFF_FFFF, 1'b1, -32'sd1, cqf_pkg::STS_EMPTY);
        add_row(cqf_pkg::CMD_PEEK_REAR,  32'sh8000_0000, 1'b1, -32'sd1, cqf_pkg::STS_EMPTY);
        add_row(cqf_pkg::CMD_ENQ,        32'sh7FFF_FFFF, 1'b1, '0,      cqf_pkg::STS_OK);
        add_row(cqf_pkg::CMD_PEEK_REAR,  -32'sd1,        1'b0, '0,      cqf_pkg::STS_OK);
        add_row(cqf_pkg::CMD_DEQ,        32'sd0,         1'b0, '0,      cqf_pkg::STS_OK);
        // Filling the whole ring writes every slot before any capacity change.
        for (int k = 0; k < cqf_pkg::DEPTH; k++) begin
            add_row(cqf_pkg::CMD_ENQ, (k == 0) ? 32'sh8000_0000 : (k == 1) ? -32'sd1 :
                    $signed(32'(k) * 32'h2468_ACE1), 1'b1, '0, cqf_pkg::STS_OK);
        end
        add_row(cqf_pkg::CMD_ENQ,        -32'sd1,        1'b1, '0,      cqf_pkg::STS_FULL);
        add_row(cqf_pkg::CMD_PEEK_FRONT, 32'sd0,         1'b0, '0,      cqf_pkg::STS_OK);
        add_row(cqf_pkg::CMD_PEEK_REAR,  32'sd0,         1'b0, '0,      cqf_pkg::STS_OK);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            offer_item(directed_rows[n].cmd, directed_rows[n].value, directed_rows[n].typed,
                       directed_rows[n].data, directed_rows[n].status);
        end
        i_in_valid <= 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Capacity changes only while nothing is in flight; the queue may still hold data.
            wait_drained();
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= cqf_pkg::CAP_W'(PHASE_CAP[ph]);
            @(posedge i_clk);
            i_cfg_we      <= 1'b0;
            send_idle_pct  = PHASE_IDLE[ph];
            stall_pct      = PHASE_STALL[ph];
            mood_left      = 0;
            enq_heavy      = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Alternate filling and draining bursts so full and empty are both reached.
                if (mood_left == 0) begin
                    enq_heavy = ~enq_heavy;
                    mood_left = $urandom_range(8, 30);
                end
                mood_left--;
                pick = $urandom_range(0, 99);
                if (enq_heavy)
                    pick_cmd = (pick < 60) ? cqf_pkg::CMD_ENQ :
                               (pick < 80) ? cqf_pkg::CMD_DEQ :
                               (pick < 90) ? cqf_pkg::CMD_PEEK_FRONT : cqf_pkg::CMD_PEEK_REAR;
                else
                    pick_cmd = (pick < 25) ? cqf_pkg::CMD_ENQ :
                               (pick < 75) ? cqf_pkg::CMD_DEQ :
                               (pick < 88) ? cqf_pkg::CMD_PEEK_FRONT : cqf_pkg::CMD_PEEK_REAR;
                case ($urandom_range(0, 15))
                    0:       pick_value = 32'sh8000_0000;
                    1:       pick_value = 32'sh7FFF_FFFF;
                    2:       pick_value = -32'sd1;
                    3:       pick_value = 32'sd0;
                    default: pick_value = $signed($urandom);
                endcase
                if (ph == HOLD_PHASE && n == 40) hold_go = 1'b1;
                offer_item(pick_cmd, pick_value, 1'b0, '0, cqf_pkg::STS_OK);
            end
            i_in_valid <= 1'b0;
        end

        wait_drained();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("circular_queue_fifo_top verification clean");
        end else begin
            $display("circular_queue_fifo_top verification failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/cqf_pkg.sv
sv/cqf_ram.sv
sv/cqf_ctrl.sv
sv/circular_queue_fifo_top.sv
tb/sv/circular_queue_fifo_top_tb.sv
